// ----- hw/rtl/sha224_pkg.sv -----
// Shared constants, round tables and controller-to-datapath types for the SHA-224 hasher.
package sha224_pkg;

	// Byte positions inside a 64-byte block and counter end values.
	localparam logic [5:0] LenPos    = 6'd56;
	localparam logic [5:0] LastPos   = 6'd63;
	localparam logic [5:0] LastRound = 6'd63;
	localparam logic [2:0] LastWord  = 3'd6;
	localparam logic [7:0] PadMark   = 8'h80;

	localparam logic [31:0] InitH [8] = '{
		32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
		32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
	};

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// Source of the byte shifted into the block window.
	typedef enum logic [1:0] {
		SRC_DATA,
		SRC_MARK,
		SRC_ZERO,
		SRC_LEN
	} byte_src_t;

	typedef struct packed {
		logic       push;
		byte_src_t  src;
		logic       latch_len;
		logic       init_v;
		logic       round_en;
		logic [5:0] round_idx;
		logic       final_add;
		logic       reinit_hash;
		logic [2:0] word_idx;
	} dp_cmd_t;

	typedef struct packed {
		logic [5:0] fill;
	} dp_stat_t;

endpackage

// ----- hw/rtl/sha224_if.sv -----
// Valid/ready channel interfaces for message bytes and digest words.
interface sha224_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       finish;

	modport source(output valid, data_byte, byte_valid, finish, input ready);
	modport sink(input valid, data_byte, byte_valid, finish, output ready);
endinterface

interface sha224_dig_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source(output valid, digest_word, word_index, last_word, input ready);
	modport sink(input valid, digest_word, word_index, last_word, output ready);
endinterface

// ----- hw/rtl/sha224_ctrl.sv -----
// Sequencer for byte loading, padding, the 64 compression rounds and digest output.
module sha224_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               msg_valid,
	input  logic               msg_byte_valid,
	input  logic               msg_finish,
	output logic               msg_ready,
	output logic               dig_valid,
	input  logic               dig_ready,
	input  sha224_pkg::dp_stat_t stat,
	output sha224_pkg::dp_cmd_t  cmd
);
	import sha224_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_ROUND,
		ST_FINAL,
		ST_PAD,
		ST_EMIT
	} state_t;

	state_t     state_q;
	logic [5:0] round_q;
	logic [2:0] widx_q;
	logic       fin_q;
	logic       pad_q;
	logic       mark_q;
	logic       len_q;
	logic       msg_acc;
	logic       dig_acc;
	logic       wrap;

	always_comb begin
		cmd           = '0;
		cmd.round_idx = round_q;
		cmd.word_idx  = widx_q;
		msg_ready     = (state_q == ST_IDLE);
		dig_valid     = (state_q == ST_EMIT);
		msg_acc       = msg_valid && msg_ready;
		dig_acc       = dig_valid && dig_ready;
		case (state_q)
			ST_IDLE: begin
				cmd.push      = msg_acc && msg_byte_valid;
				cmd.src       = SRC_DATA;
				cmd.latch_len = msg_acc && msg_finish;
			end
			ST_INIT:  cmd.init_v    = 1'b1;
			ST_ROUND: cmd.round_en  = 1'b1;
			ST_FINAL: cmd.final_add = 1'b1;
			ST_PAD: begin
				cmd.push = 1'b1;
				if (!mark_q) begin
					cmd.src = SRC_MARK;
				end else if (len_q || (stat.fill == LenPos)) begin
					cmd.src = SRC_LEN;
				end else begin
					cmd.src = SRC_ZERO;
				end
			end
			ST_EMIT: cmd.reinit_hash = dig_acc && (widx_q == LastWord);
			default: ;
		endcase
		wrap = cmd.push && (stat.fill == LastPos);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			round_q <= '0;
			widx_q  <= '0;
			fin_q   <= 1'b0;
			pad_q   <= 1'b0;
			mark_q  <= 1'b0;
			len_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (msg_acc) begin
						fin_q <= msg_finish;
						if (wrap) begin
							state_q <= ST_INIT;
						end else if (msg_finish) begin
							state_q <= ST_PAD;
							pad_q   <= 1'b1;
							mark_q  <= 1'b0;
							len_q   <= 1'b0;
						end
					end
				end
				ST_INIT: begin
					round_q <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == LastRound) begin
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					if (pad_q && len_q) begin
						state_q <= ST_EMIT;
						widx_q  <= '0;
					end else if (pad_q) begin
						state_q <= ST_PAD;
					end else if (fin_q) begin
						state_q <= ST_PAD;
						fin_q   <= 1'b0;
						pad_q   <= 1'b1;
						mark_q  <= 1'b0;
						len_q   <= 1'b0;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_PAD: begin
					mark_q <= 1'b1;
					if (cmd.src == SRC_LEN) begin
						len_q <= 1'b1;
					end
					if (wrap) begin
						state_q <= ST_INIT;
					end
				end
				ST_EMIT: begin
					if (dig_acc) begin
						widx_q <= widx_q + 3'd1;
						if (widx_q == LastWord) begin
							state_q <= ST_IDLE;
							pad_q   <= 1'b0;
							len_q   <= 1'b0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- hw/rtl/sha224_dp.sv -----
// Block window, message schedule, round unit, chaining words and length counter.
module sha224_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           data_byte,
	input  sha224_pkg::dp_cmd_t  cmd,
	output sha224_pkg::dp_stat_t stat,
	output logic [31:0]          digest_word
);
	import sha224_pkg::*;

	// The window holds the sixteen schedule words, word 0 in the top bits.
	logic [511:0] win_q;
	logic [5:0]   fill_q;
	logic [63:0]  count_q;
	logic [63:0]  len_sh_q;
	logic [31:0]  v_q    [8];
	logic [31:0]  hash_q [8];

	logic [7:0]  push_byte;
	logic        push_data;
	logic [63:0] count_plus;
	logic [31:0] w0, w1, w9, w14, w_new;
	logic [31:0] s0e, s1e, ch, maj, t1, t2;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	always_comb begin
		case (cmd.src)
			SRC_DATA: push_byte = data_byte;
			SRC_MARK: push_byte = PadMark;
			SRC_ZERO: push_byte = 8'h00;
			SRC_LEN:  push_byte = len_sh_q[63:56];
			default:  push_byte = 8'h00;
		endcase
		push_data  = cmd.push && (cmd.src == SRC_DATA);
		count_plus = count_q + {63'd0, push_data};

		w0    = win_q[511:480];
		w1    = win_q[479:448];
		w9    = win_q[223:192];
		w14   = win_q[63:32];
		w_new = w0 + w9
			+ (rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3))
			+ (rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10));

		s1e = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
		ch  = v_q[6] ^ (v_q[4] & (v_q[5] ^ v_q[6]));
		t1  = v_q[7] + s1e + ch + RoundK[cmd.round_idx] + w0;
		s0e = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
		maj = (v_q[0] & v_q[1]) | (v_q[2] & (v_q[0] | v_q[1]));
		t2  = s0e + maj;
	end

	assign stat.fill   = fill_q;
	assign digest_word = hash_q[cmd.word_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			count_q <= '0;
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= InitH[i];
			end
		end else begin
			if (cmd.push) begin
				fill_q <= fill_q + 6'd1;
			end
			if (cmd.latch_len) begin
				count_q <= '0;
			end else if (push_data) begin
				count_q <= count_plus;
			end
			if (cmd.final_add) begin
				for (int i = 0; i < 8; i++) begin
					hash_q[i] <= hash_q[i] + v_q[i];
				end
			end else if (cmd.reinit_hash) begin
				for (int i = 0; i < 8; i++) begin
					hash_q[i] <= InitH[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			win_q <= {win_q[503:0], push_byte};
		end else if (cmd.round_en) begin
			win_q <= {win_q[479:0], w_new};
		end
		if (cmd.latch_len) begin
			len_sh_q <= {count_plus[60:0], 3'b000};
		end else if (cmd.push && (cmd.src == SRC_LEN)) begin
			len_sh_q <= {len_sh_q[55:0], 8'h00};
		end
		if (cmd.init_v) begin
			v_q <= hash_q;
		end else if (cmd.round_en) begin
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
		end
	end

endmodule

// ----- hw/rtl/sha224_stream_hash_core.sv -----
// SHA-224 byte-stream hasher: top level joining the sequencer and the datapath.
// Each message beat is taken while the hasher is idle; every 64th byte starts a compression
// (a load of the working variables, 64 rounds, a chaining add) with the message channel stalled.
// After a finish beat, padding goes in one byte per cycle and runs through one or two compressions
// before the first digest beat; the seven words follow one per ready cycle.
// Reset (arst_n low, asynchronous) restores the initial chaining words and clears the count.
module sha224_stream_hash_core (
	input logic          clk,
	input logic          arst_n,
	sha224_msg_if.sink   msg,
	sha224_dig_if.source dig
);
	import sha224_pkg::*;

	dp_cmd_t     cmd;
	dp_stat_t    stat;
	logic [31:0] word;

	// The sequencer accepts message beats only while idle; the round loop and the padding
	// sequence run with the message channel stalled.
	sha224_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.msg_valid      (msg.valid),
		.msg_byte_valid (msg.byte_valid),
		.msg_finish     (msg.finish),
		.msg_ready      (msg.ready),
		.dig_valid      (dig.valid),
		.dig_ready      (dig.ready),
		.stat           (stat),
		.cmd            (cmd)
	);

	// The datapath holds the block window, which doubles as the rolling message schedule,
	// the working variables, the chaining words and the 64-bit byte counter.
	sha224_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_byte   (msg.data_byte),
		.cmd         (cmd),
		.stat        (stat),
		.digest_word (word)
	);

	// Digest beats are read straight out of the chaining registers, which stay put until
	// the last word is taken, so a stalled beat holds its payload.
	assign dig.digest_word = word;
	assign dig.word_index  = cmd.word_idx;
	assign dig.last_word   = (cmd.word_idx == LastWord);

endmodule

// ----- hw/rtl/sha224_chk.sv -----
// Port-level checker for the SHA-224 hasher, bound to the top level.
module sha224_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        msg_valid,
	input logic        msg_ready,
	input logic        dig_valid,
	input logic        dig_ready,
	input logic [31:0] digest_word,
	input logic [2:0]  word_index,
	input logic        last_word
);

	a_dig_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && !dig_ready |=> dig_valid && $stable(digest_word) && $stable(word_index))
		else $error("digest beat changed while stalled");

	a_word_seq: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && dig_ready && !last_word |=>
			dig_valid && (word_index == $past(word_index) + 3'd1))
		else $error("digest words not consecutive");

	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid |-> (last_word == (word_index == 3'd6)))
		else $error("last word flag misplaced");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(msg_ready && dig_valid))
		else $error("message accepted while digest pending");

	a_back_idle: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && dig_ready && last_word |=> msg_ready && !dig_valid)
		else $error("hasher did not return to idle after digest");

endmodule

bind sha224_stream_hash_core sha224_chk u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.msg_valid   (msg.valid),
	.msg_ready   (msg.ready),
	.dig_valid   (dig.valid),
	.dig_ready   (dig.ready),
	.digest_word (dig.digest_word),
	.word_index  (dig.word_index),
	.last_word   (dig.last_word)
);
